// ----- design/nrmc_pkg.sv -----
// Package for the RMC sentence parser: status codes, character constants and helpers.
// No dependencies.
`default_nettype none
package nrmc_pkg;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_COMMAS   = 3'd1,
    ST_HEADER   = 3'd2,
    ST_NO_CR    = 3'd3,
    ST_BAD_FLD  = 3'd4
  } status_t;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [3:0] COMMA_LIMIT = 4'd13;
  localparam logic [3:0] COMMA_SAT   = 4'd14;
  localparam logic [3:0] COMMA_MIN   = 4'd10;
  localparam logic [19:0] SPEED_MAX  = 20'd999999;
  localparam logic [11:0] YEAR_BASE  = 12'd2000;
  localparam logic [4:0] FLEN_MAX    = 5'd31;

  // Header text after the dollar sign, indexed by header position minus one
  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = 8'h47; // G
      3'd1: c = 8'h4E; // N
      3'd2: c = 8'h52; // R
      3'd3: c = 8'h4D; // M
      3'd4: c = 8'h43; // C
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic [3:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    d = c - CH_ZERO;
    return is_digit(c) ? d[3:0] : 4'd0;
  endfunction

  function automatic logic [3:0] char_code(input logic [7:0] c);
    logic [3:0] r;
    if (is_digit(c)) r = digit_of(c);
    else if (c == CH_DOT) r = 4'd10;
    else r = 4'd14;
    return r;
  endfunction

  // Two BCD nibbles to a binary value 0..99
  function automatic logic [6:0] two_digits(input logic [7:0] bcd);
    logic [6:0] hi;
    hi = {3'd0, bcd[7:4]};
    return (hi << 3) + (hi << 1) + {3'd0, bcd[3:0]};
  endfunction

endpackage
`default_nettype wire

// ----- design/nmea_rmc_sentence_parser_core.sv -----
// Top level of the RMC sentence parser: byte-wise sentence capture and result register.
// Depends on nrmc_pkg.
//
//  channel | direction | ports                         | transaction
//  in_     | input     | in_valid, in_stall, in_rx_byte | one received byte
//  out_    | output    | out_valid, out_stall, fields   | one parsed sentence
//
// Parse state updates at the edge the byte is accepted.
// A line feed inside a sentence loads the result register; out_valid rises next cycle.
// Input stalls only when a result is waiting and the incoming byte would make another
// one (line feed); other bytes are taken regardless of the output side.
// Reset (rst_n low, synchronous) clears the parse state and the output valid.
`default_nettype none
module nmea_rmc_sentence_parser_core #(
  parameter int LAT_MAX_CHARS   = 11,
  parameter int LON_MAX_CHARS   = 10,
  parameter int FIELD_MAX_CHARS = 31
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic             out_fix_valid,
  output logic [6:0]       out_utc_hour,
  output logic [6:0]       out_utc_minute,
  output logic [6:0]       out_utc_second,
  output logic [47:0]      out_latitude_chars,
  output logic [47:0]      out_longitude_chars,
  output logic [15:0]      out_hemisphere_chars,
  output logic [19:0]      out_speed_milli_knots,
  output logic [6:0]       out_utc_day,
  output logic [6:0]       out_utc_month,
  output logic [11:0]      out_utc_year
);
  import nrmc_pkg::*;

  localparam logic [4:0] FMAX = 5'(FIELD_MAX_CHARS);
  localparam logic [4:0] LATMAX = 5'(LAT_MAX_CHARS);
  localparam logic [4:0] LONMAX = 5'(LON_MAX_CHARS);

  // parse state
  logic        in_sent_r, in_sent_nxt;
  logic [2:0]  hpos_r, hpos_nxt;
  logic [3:0]  commas_r, commas_nxt;
  logic [4:0]  flen_r, flen_nxt;
  logic        prev_cr_r, prev_cr_nxt;
  logic [2:0]  err_r, err_nxt;
  logic [23:0] time_r, time_nxt;
  logic [23:0] date_r, date_nxt;
  logic        vflag_r, vflag_nxt;
  logic [47:0] lat_r, lat_nxt;
  logic [47:0] lon_r, lon_nxt;
  logic [15:0] hemi_r, hemi_nxt;
  logic [19:0] spd_r, spd_nxt;
  logic [1:0]  fcnt_r, fcnt_nxt;
  logic        dot_r, dot_nxt;
  logic        halt_r, halt_nxt;

  // result register
  logic        ovld_r, ovld_nxt;
  logic [2:0]  ostat_r, ostat_nxt;
  logic        ofix_r, ofix_nxt;
  logic [6:0]  ohr_r, ohr_nxt, omin_r, omin_nxt, osec_r, osec_nxt;
  logic [47:0] olat_r, olat_nxt, olon_r, olon_nxt;
  logic [15:0] ohemi_r, ohemi_nxt;
  logic [19:0] ospd_r, ospd_nxt;
  logic [6:0]  oday_r, oday_nxt, omon_r, omon_nxt;
  logic [11:0] oyr_r, oyr_nxt;

  logic [7:0] c;
  logic       is_lf, in_acc, out_acc, ends;
  logic       captured;
  logic [2:0] stat;
  logic [23:0] spd_mul;
  logic [23:0] spd_add;
  logic [23:0] spd_sum;

  assign c        = in_rx_byte;
  assign is_lf    = (c == CH_LF);
  assign in_stall = ovld_r && out_stall && is_lf && in_sent_r;
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = ovld_r && !out_stall;
  assign ends     = in_acc && in_sent_r && is_lf && (c != CH_DOLLAR);
  assign captured = ((commas_r >= 4'd1) && (commas_r <= 4'd7)) || (commas_r == 4'd9);

  // Speed datapath: whole digit shifts by ten, fraction digit adds its weight
  always_comb begin
    logic [23:0] d;
    d = {20'd0, digit_of(c)};
    spd_mul = dot_r ? {4'd0, spd_r} : ({4'd0, spd_r} << 3) + ({4'd0, spd_r} << 1);
    case (dot_r ? fcnt_r : 2'd3)
      2'd0: spd_add = (d << 6) + (d << 5) + (d << 2);
      2'd1: spd_add = (d << 3) + (d << 1);
      2'd2: spd_add = d;
      default: spd_add = (d << 10) - (d << 4) - (d << 3);
    endcase
    spd_sum = spd_mul + spd_add;
  end

  // Sentence status at the line feed
  always_comb begin
    if (commas_r > COMMA_LIMIT) stat = ST_COMMAS;
    else if (hpos_r < 3'd6 || err_r == ST_HEADER) stat = ST_HEADER;
    else if (!prev_cr_r) stat = ST_NO_CR;
    else if (err_r == ST_BAD_FLD || commas_r < COMMA_MIN) stat = ST_BAD_FLD;
    else stat = ST_OK;
  end

  // Parse state next value
  always_comb begin
    logic [2:0] e;
    logic [5:0] sh;
    e = 3'd0;
    sh = 6'd0;
    in_sent_nxt = in_sent_r; hpos_nxt = hpos_r; commas_nxt = commas_r;
    flen_nxt = flen_r; prev_cr_nxt = prev_cr_r; err_nxt = err_r;
    time_nxt = time_r; date_nxt = date_r; vflag_nxt = vflag_r;
    lat_nxt = lat_r; lon_nxt = lon_r; hemi_nxt = hemi_r; spd_nxt = spd_r;
    fcnt_nxt = fcnt_r; dot_nxt = dot_r; halt_nxt = halt_r;
    if (in_acc) begin
      if (c == CH_DOLLAR) begin
        in_sent_nxt = 1'b1; hpos_nxt = 3'd1; commas_nxt = '0; flen_nxt = '0;
        prev_cr_nxt = 1'b0; err_nxt = '0; time_nxt = '0; date_nxt = '0;
        vflag_nxt = 1'b0; lat_nxt = '1; lon_nxt = '1; hemi_nxt = '0;
        spd_nxt = '0; fcnt_nxt = '0; dot_nxt = 1'b0; halt_nxt = 1'b0;
      end else if (in_sent_r && is_lf) begin
        in_sent_nxt = 1'b0;
      end else if (in_sent_r) begin
        // header check
        if (hpos_r >= 3'd1 && hpos_r < 3'd6) begin
          if (c != hdr_char(hpos_r - 3'd1)) e = ST_HEADER;
          hpos_nxt = hpos_r + 3'd1;
        end
        prev_cr_nxt = (c == CH_CR);
        if (c == CH_COMMA) begin
          // close the field
          if ((commas_r == 4'd1 || commas_r == 4'd9) && flen_r < 5'd6) e = ST_BAD_FLD;
          if ((commas_r == 4'd2 || commas_r == 4'd4 || commas_r == 4'd6) && flen_r != 5'd1)
            e = ST_BAD_FLD;
          if (commas_r < COMMA_SAT) commas_nxt = commas_r + 4'd1;
          flen_nxt = '0;
        end else if (captured && flen_r >= FMAX) begin
          e = ST_BAD_FLD;
        end else begin
          if (flen_r < FLEN_MAX) flen_nxt = flen_r + 5'd1;
          case (commas_r)
            4'd1: if (flen_r < 5'd6) begin
              sh = 6'd20 - {flen_r[3:0], 2'b00};
              time_nxt = (time_r & ~(24'hF << sh)) | ({20'd0, digit_of(c)} << sh);
            end
            4'd2: if (flen_r == 5'd0) vflag_nxt = (c == CH_A);
            4'd3: if (flen_r < LATMAX) begin
              if (flen_r < 5'd12) begin
                sh = 6'd44 - {flen_r[3:0], 2'b00};
                lat_nxt = (lat_r & ~(48'hF << sh)) | ({44'd0, char_code(c)} << sh);
              end
            end else e = ST_BAD_FLD;
            4'd4: if (flen_r == 5'd0) hemi_nxt = {c, hemi_r[7:0]};
            4'd5: if (flen_r < LONMAX) begin
              if (flen_r < 5'd12) begin
                sh = 6'd44 - {flen_r[3:0], 2'b00};
                lon_nxt = (lon_r & ~(48'hF << sh)) | ({44'd0, char_code(c)} << sh);
              end
            end else e = ST_BAD_FLD;
            4'd6: if (flen_r == 5'd0) hemi_nxt = {hemi_r[15:8], c};
            4'd7: if (!halt_r) begin
              if (is_digit(c)) begin
                if (!dot_r || fcnt_r < 2'd3) begin
                  spd_nxt = (spd_sum > {4'd0, SPEED_MAX}) ? SPEED_MAX : spd_sum[19:0];
                  if (dot_r) fcnt_nxt = fcnt_r + 2'd1;
                end
              end else if (c == CH_DOT && !dot_r) dot_nxt = 1'b1;
              else halt_nxt = 1'b1;
            end
            4'd9: if (flen_r < 5'd6) begin
              sh = 6'd20 - {flen_r[3:0], 2'b00};
              date_nxt = (date_r & ~(24'hF << sh)) | ({20'd0, digit_of(c)} << sh);
            end
            default: ;
          endcase
        end
        if (e != 3'd0 && (err_r == 3'd0 || e < err_r)) err_nxt = e;
      end
    end
  end

  // Result register next value: load on sentence end, drop valid when taken
  always_comb begin
    logic ok;
    ok = (stat == ST_OK);
    ovld_nxt = ovld_r; ostat_nxt = ostat_r; ofix_nxt = ofix_r;
    ohr_nxt = ohr_r; omin_nxt = omin_r; osec_nxt = osec_r;
    olat_nxt = olat_r; olon_nxt = olon_r; ohemi_nxt = ohemi_r; ospd_nxt = ospd_r;
    oday_nxt = oday_r; omon_nxt = omon_r; oyr_nxt = oyr_r;
    if (out_acc) ovld_nxt = 1'b0;
    if (ends) begin
      ovld_nxt  = 1'b1;
      ostat_nxt = stat;
      ofix_nxt  = ok && vflag_r;
      ohr_nxt   = ok ? two_digits(time_r[23:16]) : 7'd0;
      omin_nxt  = ok ? two_digits(time_r[15:8]) : 7'd0;
      osec_nxt  = ok ? two_digits(time_r[7:0]) : 7'd0;
      olat_nxt  = ok ? lat_r : 48'd0;
      olon_nxt  = ok ? lon_r : 48'd0;
      ohemi_nxt = ok ? hemi_r : 16'd0;
      ospd_nxt  = ok ? spd_r : 20'd0;
      oday_nxt  = ok ? two_digits(date_r[23:16]) : 7'd0;
      omon_nxt  = ok ? two_digits(date_r[15:8]) : 7'd0;
      oyr_nxt   = ok ? YEAR_BASE + {5'd0, two_digits(date_r[7:0])} : 12'd0;
    end
  end

  // Advance registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_sent_r <= 1'b0; hpos_r <= '0; commas_r <= '0; flen_r <= '0;
      prev_cr_r <= 1'b0; err_r <= '0; time_r <= '0; date_r <= '0;
      vflag_r <= 1'b0; lat_r <= '1; lon_r <= '1; hemi_r <= '0;
      spd_r <= '0; fcnt_r <= '0; dot_r <= 1'b0; halt_r <= 1'b0;
      ovld_r <= 1'b0;
    end else begin
      in_sent_r <= in_sent_nxt; hpos_r <= hpos_nxt; commas_r <= commas_nxt;
      flen_r <= flen_nxt; prev_cr_r <= prev_cr_nxt; err_r <= err_nxt;
      time_r <= time_nxt; date_r <= date_nxt; vflag_r <= vflag_nxt;
      lat_r <= lat_nxt; lon_r <= lon_nxt; hemi_r <= hemi_nxt;
      spd_r <= spd_nxt; fcnt_r <= fcnt_nxt; dot_r <= dot_nxt; halt_r <= halt_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  // Hold result payload
  always_ff @(posedge clk) begin
    ostat_r <= ostat_nxt; ofix_r <= ofix_nxt; ohr_r <= ohr_nxt; omin_r <= omin_nxt;
    osec_r <= osec_nxt; olat_r <= olat_nxt; olon_r <= olon_nxt; ohemi_r <= ohemi_nxt;
    ospd_r <= ospd_nxt; oday_r <= oday_nxt; omon_r <= omon_nxt; oyr_r <= oyr_nxt;
  end

  assign out_valid             = ovld_r;
  assign out_status            = ostat_r;
  assign out_fix_valid         = ofix_r;
  assign out_utc_hour          = ohr_r;
  assign out_utc_minute        = omin_r;
  assign out_utc_second        = osec_r;
  assign out_latitude_chars    = olat_r;
  assign out_longitude_chars   = olon_r;
  assign out_hemisphere_chars  = ohemi_r;
  assign out_speed_milli_knots = ospd_r;
  assign out_utc_day           = oday_r;
  assign out_utc_month         = omon_r;
  assign out_utc_year          = oyr_r;

  // Checks
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    ovld_r && out_stall |-> !ends) else $error("result overwritten");
  a_end_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ends |=> ovld_r) else $error("missing result");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ovld_r && ostat_r != ST_OK |-> ospd_r == 20'd0 && !ofix_r)
    else $error("error result not cleared");
  a_spd_sat: assert property (@(posedge clk) disable iff (!rst_n)
    spd_r <= SPEED_MAX) else $error("speed over limit");

endmodule
`default_nettype wire

// ----- dv/nmea_rmc_sentence_parser_core_tb.sv -----
// Testbench for the RMC sentence parser core: drives byte streams, predicts each parsed
// sentence with its own parser state machine and checks every result field by field.
// Depends on nrmc_pkg and nmea_rmc_sentence_parser_core.
`default_nettype none
module nmea_rmc_sentence_parser_core_tb;
  import nrmc_pkg::*;

  localparam int LAT_CHARS   = 11;
  localparam int LON_CHARS   = 10;
  localparam int FIELD_CHARS = 31;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [2:0]  status;
    logic        fix_valid;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [47:0] lat;
    logic [47:0] lon;
    logic [15:0] hemi;
    logic [19:0] speed;
    logic [6:0]  day;
    logic [6:0]  month;
    logic [11:0] year;
  } fix_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic        out_fix_valid;
  logic [6:0]  out_utc_hour, out_utc_minute, out_utc_second;
  logic [47:0] out_latitude_chars, out_longitude_chars;
  logic [15:0] out_hemisphere_chars;
  logic [19:0] out_speed_milli_knots;
  logic [6:0]  out_utc_day, out_utc_month;
  logic [11:0] out_utc_year;

  nmea_rmc_sentence_parser_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_fix_valid(out_fix_valid), .out_utc_hour(out_utc_hour),
    .out_utc_minute(out_utc_minute), .out_utc_second(out_utc_second),
    .out_latitude_chars(out_latitude_chars), .out_longitude_chars(out_longitude_chars),
    .out_hemisphere_chars(out_hemisphere_chars),
    .out_speed_milli_knots(out_speed_milli_knots),
    .out_utc_day(out_utc_day), .out_utc_month(out_utc_month), .out_utc_year(out_utc_year)
  );

  always begin
    clk = 1'b0; #1;
    clk = 1'b1; #1;
  end

  // Parser state of the predictor
  logic        p_active;
  logic [2:0]  p_hdr_pos;
  logic [3:0]  p_commas;
  logic [4:0]  p_flen;
  logic        p_last_cr;
  logic [2:0]  p_err;
  logic [23:0] p_time;
  logic [23:0] p_date;
  logic        p_fix;
  logic [47:0] p_lat;
  logic [47:0] p_lon;
  logic [15:0] p_hemi;
  logic [19:0] p_speed;
  logic [1:0]  p_frac;
  logic        p_dot;
  logic        p_halt;

  fix_t expected_fixes[$];
  int   fail_count;
  int   cycle_count;
  int   bytes_sent;
  int   fixes_checked;
  int   send_idle_pct;
  int   recv_idle_pct;

  task automatic clear_parser();
    p_active = 1'b0; p_hdr_pos = '0; p_commas = '0; p_flen = '0; p_last_cr = 1'b0;
    p_err = '0; p_time = '0; p_date = '0; p_fix = 1'b0; p_lat = '1; p_lon = '1;
    p_hemi = '0; p_speed = '0; p_frac = '0; p_dot = 1'b0; p_halt = 1'b0;
  endtask

  function automatic logic [3:0] nib_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 4'(c - "0");
    return (c == ".") ? 4'd10 : 4'd14;
  endfunction

  function automatic logic [3:0] bcd_of(input logic [7:0] c);
    return (c >= "0" && c <= "9") ? 4'(c - "0") : 4'd0;
  endfunction

  function automatic logic [6:0] pair_val(input logic [23:0] s, input int first);
    return 7'(s[23 - 4*first -: 4] * 10 + s[19 - 4*first -: 4]);
  endfunction

  task automatic flag_error(input logic [2:0] code);
    if (p_err == 0 || code < p_err) p_err = code;
  endtask

  function automatic logic [19:0] clip_speed(input longint v);
    return (v > 999999) ? SPEED_MAX : 20'(v);
  endfunction

  task automatic accumulate_speed(input logic [7:0] c);
    int w;
    if (p_halt) return;
    if (c >= "0" && c <= "9") begin
      if (!p_dot) p_speed = clip_speed(longint'(p_speed) * 10 + (c - "0") * 1000);
      else if (p_frac < 3) begin
        w = (p_frac == 0) ? 100 : (p_frac == 1) ? 10 : 1;
        p_speed = clip_speed(longint'(p_speed) + (c - "0") * w);
        p_frac++;
      end
    end else if (c == CH_DOT && !p_dot) begin
      p_dot = 1'b1;
    end else begin
      p_halt = 1'b1;
    end
  endtask

  task automatic capture_char(input logic [7:0] c);
    int k, p;
    logic take;
    k = p_commas; p = p_flen;
    take = (k >= 1 && k <= 7) || k == 9;
    if (take && p >= FIELD_CHARS) begin
      flag_error(ST_BAD_FLD);
      return;
    end
    if (p_flen < 31) p_flen++;
    if (!take) return;
    case (k)
      1: if (p < 6) p_time[23 - 4*p -: 4] = bcd_of(c);
      2: if (p == 0) p_fix = (c == CH_A);
      3: if (p < LAT_CHARS) p_lat[47 - 4*p -: 4] = nib_of(c); else flag_error(ST_BAD_FLD);
      4: if (p == 0) p_hemi[15:8] = c;
      5: if (p < LON_CHARS) p_lon[47 - 4*p -: 4] = nib_of(c); else flag_error(ST_BAD_FLD);
      6: if (p == 0) p_hemi[7:0] = c;
      7: accumulate_speed(c);
      default: if (p < 6) p_date[23 - 4*p -: 4] = bcd_of(c);
    endcase
  endtask

  // Advance the predictor by one accepted byte; queue a fix on a line feed
  task automatic predict_fix(input logic [7:0] c);
    fix_t f;
    if (c == CH_DOLLAR) begin
      clear_parser();
      p_active = 1'b1; p_hdr_pos = 3'd1;
      return;
    end
    if (!p_active) return;
    if (c == CH_LF) begin
      f = '0;
      if (p_commas > COMMA_LIMIT) f.status = ST_COMMAS;
      else if (p_hdr_pos < 6 || p_err == ST_HEADER) f.status = ST_HEADER;
      else if (!p_last_cr) f.status = ST_NO_CR;
      else if (p_err == ST_BAD_FLD || p_commas < COMMA_MIN) f.status = ST_BAD_FLD;
      else f.status = ST_OK;
      if (f.status == ST_OK) begin
        f.fix_valid = p_fix;
        f.hour = pair_val(p_time, 0); f.minute = pair_val(p_time, 2);
        f.second = pair_val(p_time, 4);
        f.lat = p_lat; f.lon = p_lon; f.hemi = p_hemi; f.speed = p_speed;
        f.day = pair_val(p_date, 0); f.month = pair_val(p_date, 2);
        f.year = 12'(pair_val(p_date, 4)) + YEAR_BASE;
      end
      expected_fixes.push_back(f);
      p_active = 1'b0;
      return;
    end
    if (p_hdr_pos >= 1 && p_hdr_pos < 6) begin
      if (c != hdr_char(p_hdr_pos - 3'd1)) flag_error(ST_HEADER);
      p_hdr_pos++;
    end
    p_last_cr = (c == CH_CR);
    if (c == CH_COMMA) begin
      if ((p_commas == 1 || p_commas == 9) && p_flen < 6) flag_error(ST_BAD_FLD);
      if ((p_commas == 2 || p_commas == 4 || p_commas == 6) && p_flen != 1)
        flag_error(ST_BAD_FLD);
      if (p_commas < COMMA_SAT) p_commas++;
      p_flen = '0;
    end else begin
      capture_char(c);
    end
  endtask

  // Send one byte: optional idle gap, then hold until accepted
  task automatic send_byte(input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_fix(c);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic drain_fixes();
    in_valid <= 1'b0;
    while (expected_fixes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Compare each accepted fix against the oldest prediction
  always @(posedge clk) begin
    fix_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_fixes.size() == 0) begin
        $error("unexpected fix transaction, status %0d", out_status);
        fail_count++;
      end else begin
        e = expected_fixes.pop_front();
        fixes_checked++;
        if (out_status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_status); fail_count++;
        end
        if (out_fix_valid !== e.fix_valid) begin
          $error("fix_valid exp %0d got %0d", e.fix_valid, out_fix_valid); fail_count++;
        end
        if (out_utc_hour !== e.hour) begin
          $error("utc_hour exp %0d got %0d", e.hour, out_utc_hour); fail_count++;
        end
        if (out_utc_minute !== e.minute) begin
          $error("utc_minute exp %0d got %0d", e.minute, out_utc_minute); fail_count++;
        end
        if (out_utc_second !== e.second) begin
          $error("utc_second exp %0d got %0d", e.second, out_utc_second); fail_count++;
        end
        if (out_latitude_chars !== e.lat) begin
          $error("latitude_chars exp %h got %h", e.lat, out_latitude_chars); fail_count++;
        end
        if (out_longitude_chars !== e.lon) begin
          $error("longitude_chars exp %h got %h", e.lon, out_longitude_chars); fail_count++;
        end
        if (out_hemisphere_chars !== e.hemi) begin
          $error("hemisphere_chars exp %h got %h", e.hemi, out_hemisphere_chars);
          fail_count++;
        end
        if (out_speed_milli_knots !== e.speed) begin
          $error("speed_milli_knots exp %0d got %0d", e.speed, out_speed_milli_knots);
          fail_count++;
        end
        if (out_utc_day !== e.day) begin
          $error("utc_day exp %0d got %0d", e.day, out_utc_day); fail_count++;
        end
        if (out_utc_month !== e.month) begin
          $error("utc_month exp %0d got %0d", e.month, out_utc_month); fail_count++;
        end
        if (out_utc_year !== e.year) begin
          $error("utc_year exp %0d got %0d", e.year, out_utc_year); fail_count++;
        end
      end
    end
  end

  // Timeout guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL nmea_rmc_sentence_parser_core");
      $finish;
    end
  end

  function automatic string digits(input int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(9)))};
    return s;
  endfunction

  // Field text, usually well formed, sometimes odd
  function automatic string field_text(input int k);
    string s;
    int r;
    r = $urandom_range(99);
    if (r < 8) begin
      s = "";
      for (int i = $urandom_range(13); i > 0; i--)
        s = {s, string'(8'($urandom_range(32, 126) == 36 ? 65 : $urandom_range(32, 126)))};
      s = s.len() == 0 ? "" : s;
      for (int i = 0; i < s.len(); i++) if (s[i] == "," || s[i] == "$") s[i] = "x";
      return s;
    end
    case (k)
      1: return {digits(6), (r < 60) ? {".", digits($urandom_range(0, 3))} : ""};
      2: return ($urandom_range(1)) ? "A" : "V";
      3: return {digits(4), ".", digits($urandom_range(0, 6))};
      4: return ($urandom_range(1)) ? "N" : "S";
      5: return {digits(5), ".", digits($urandom_range(0, 4))};
      6: return ($urandom_range(1)) ? "E" : "W";
      7: return {digits($urandom_range(0, 7)), (r < 70) ? {".", digits($urandom_range(5))} : ""};
      9: return digits(6);
      default: return (r < 50) ? "" : digits($urandom_range(3));
    endcase
  endfunction

  task automatic send_random_sentence();
    string s;
    int ncomma;
    int r;
    r = $urandom_range(99);
    s = (r < 5) ? "$GPRMC" : (r < 8) ? "$GNR" : "$GNRMC";
    ncomma = (r < 88) ? 12 : $urandom_range(0, 16);
    for (int k = 1; k <= ncomma; k++) s = {s, ",", field_text(k)};
    if ($urandom_range(99) < 80) s = {s, "*", digits(2)};
    r = $urandom_range(99);
    s = (r < 90) ? {s, "\r\n"} : (r < 95) ? {s, "\n"} : {s, "\r"};
    send_text(s);
  endtask

  task automatic test_directed_fields();
    send_text("$GNRMC,235959.99,A,8959.999999,N,17959.9999,W,999.9999,,311299,,,A*00\r\n");
    send_text("$GNRMC,000000,V,0000.0,S,00000.0,E,0,x,010100,,\r\n");
    send_text("$GNRMC,123456,A,12x4.5,N,12345.6,E,12-3.4,,1a0599,,\r\n");
    send_text("$GNRMC,123456,A,1234.5,N,12345.6,E,5000000,,010199,,\r\n");
    drain_fixes();
  endtask

  task automatic test_directed_errors();
    send_text("$GNRMC,,,,,,,,,,,,,,,\r\n");
    send_text("$GPRMC,123456,A,1,N,1,E,1,,010199,,\r\n");
    send_text("$GN\r\n");
    send_text("$GNRMC,123456,A,1,N,1,E,1,,010199,,\n");
    send_text("$GNRMC,12345,A,1,N,1,E,1,,010199,,\r\n");
    send_text("$GNRMC,123456,AV,1,N,1,E,1,,01019,,\r\n");
    send_text("$GNRMC,123456,A,123456789012,N,12345678901,E,1,,010199,,\r\n");
    send_text("$GNRMC,123456,A,1,N,1,E,1,\r\n");
    send_text("$GNRMC,123456789012345678901234567890123,A,1,N,1,E,1,,010199,,\r\n");
    drain_fixes();
  endtask

  task automatic test_framing();
    send_text("\n\x80\xff\x00junk$GNRMC,1$GNRMCZ,123456,A,1,N,1,E,1,,010199,,\r\n");
    send_text("\n\r\n");
    drain_fixes();
  endtask

  task automatic test_random_stream(input int n_bytes);
    int stop;
    stop = bytes_sent + n_bytes;
    while (bytes_sent < stop) begin
      if ($urandom_range(99) < 6) send_byte(8'($urandom_range(255)));
      else send_random_sentence();
    end
    drain_fixes();
  endtask

  initial begin
    fail_count = 0; cycle_count = 0; bytes_sent = 0; fixes_checked = 0;
    send_idle_pct = 0; recv_idle_pct = 0;
    clear_parser();
    rst_n = 1'b0; in_valid = 1'b0; in_rx_byte = '0; out_stall = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_fields();
    test_directed_errors();
    test_framing();

    send_idle_pct = 36; recv_idle_pct = 45;
    test_random_stream(420);
    send_idle_pct = 45; recv_idle_pct = 36;
    test_random_stream(420);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random_stream(420);

    repeat (20) @(posedge clk);
    $display("Sent %0d bytes, checked %0d parsed sentences across three idle patterns.",
             bytes_sent, fixes_checked);
    if (fail_count == 0 && expected_fixes.size() == 0) begin
      $display("PASS nmea_rmc_sentence_parser_core");
    end else begin
      $display("FAIL nmea_rmc_sentence_parser_core");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- sim.f -----
design/nrmc_pkg.sv
design/nmea_rmc_sentence_parser_core.sv
dv/nmea_rmc_sentence_parser_core_tb.sv
